[hdl/sfc_pkg.sv]
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, constants and functions for the sensor frame cipher: CRC16
// column masks, byte permutation, nibble S-box and the fixed round subkeys.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

    localparam int SFC_ROUND_COUNT = 8;
    localparam int SFC_ROUND_MAX   = 16;

    localparam logic [31:0] SFC_DEVICE_ID_RST = 32'h0000_0000;
    localparam logic [15:0] SFC_CRC_POLY      = 16'h1021;
    localparam logic [15:0] SFC_CRC_INIT      = 16'hFFFF;
    localparam logic [7:0]  SFC_SK_MASK       = 8'hA5;
    localparam logic [7:0]  SFC_POOL_MASK     = 8'h5A;
    localparam logic [7:0]  SFC_MIX_ADD       = 8'h3D;

    typedef logic [79:0] sfc_block_t;
    typedef logic [39:0] sfc_half_t;
    typedef logic [7:0]  sfc_byte_t;

    localparam logic [3:0] SFC_PERM [10] = '{
        4'd3, 4'd8, 4'd1, 4'd5, 4'd0, 4'd9, 4'd4, 4'd7, 4'd2, 4'd6
    };

    localparam logic [3:0] SFC_SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    localparam logic [7:0] SFC_KEY_POOL [16] = '{
        8'hB1, 8'h13, 8'h27, 8'h58, 8'h9A, 8'hCD, 8'hEF, 8'h01,
        8'h22, 8'h44, 8'h66, 8'h88, 8'hAA, 8'hCC, 8'hEE, 8'h00
    };

    // Bitwise CRC16 over 8 bytes, byte 0 in bits 7:0, MSB first per byte.
    // Only ever called with constant arguments.
    function automatic logic [15:0] sfc_crc_calc(logic [63:0] data, logic [15:0] init);
        logic [15:0] c;
        c = init;
        for (int i = 0; i < 8; i++)
        begin
            c = c ^ {data[8*i +: 8], 8'h00};
            for (int k = 0; k < 8; k++)
            begin
                c = c[15] ? ({c[14:0], 1'b0} ^ SFC_CRC_POLY) : {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Contribution of one data bit to the CRC (the CRC is linear in data)
    function automatic logic [15:0] sfc_crc_column(int bit_idx);
        return sfc_crc_calc(64'(1) << bit_idx, 16'h0000);
    endfunction

    function automatic logic [15:0] sfc_crc_base();
        return sfc_crc_calc(64'h0, SFC_CRC_INIT);
    endfunction

    // out byte i = in byte SFC_PERM[i]
    function automatic sfc_block_t sfc_permute(sfc_block_t x);
        sfc_block_t y;
        for (int i = 0; i < 10; i++)
        begin
            y[8*i +: 8] = x[8*SFC_PERM[i] +: 8];
        end
        return y;
    endfunction

    function automatic sfc_byte_t sfc_sbox_byte(sfc_byte_t v);
        return {SFC_SBOX[v[7:4]], SFC_SBOX[v[3:0]]};
    endfunction

    // Subkey of one round; pool rotates down one byte per round, the wrapped byte XORed with SFC_POOL_MASK ^ round.
    function automatic sfc_half_t sfc_subkey(int rnd);
        logic [7:0] pool [16];
        logic [7:0] first;
        sfc_half_t  k;
        for (int j = 0; j < 16; j++)
        begin
            pool[j] = SFC_KEY_POOL[j];
        end
        for (int rr = 0; rr < rnd; rr++)
        begin
            first = pool[0];
            for (int j = 0; j < 15; j++)
            begin
                pool[j] = pool[j+1];
            end
            pool[15] = first ^ (SFC_POOL_MASK ^ 8'(rr));
        end
        for (int i = 0; i < 5; i++)
        begin
            k[8*i +: 8] = pool[(rnd + i) % 16] ^ (SFC_SK_MASK ^ 8'(rnd * 13 + i * 7));
        end
        return k;
    endfunction

endpackage

`default_nettype wire

[hdl/sfc_in_if.sv]
// ----------------------------------------------------------------------------
// sfc_in_if
// Sensor reading channel: valid/ready handshake with temperature and humidity.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature;
    logic        [15:0] humidity;

    modport source (output valid, output temperature, output humidity, input ready);
    modport sink   (input valid, input temperature, input humidity, output ready);
endinterface

`default_nettype wire

[hdl/sfc_out_if.sv]
// ----------------------------------------------------------------------------
// sfc_out_if
// Ciphertext channel: valid/ready handshake with the 10-byte ciphertext.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_low;
    logic [15:0] cipher_high;

    modport source (output valid, output cipher_low, output cipher_high, input ready);
    modport sink   (input valid, input cipher_low, input cipher_high, output ready);
endinterface

`default_nettype wire

[hdl/sfc_frame_build.sv]
// ----------------------------------------------------------------------------
// sfc_frame_build
// Assembles the 8-byte plaintext, appends its CRC16 and applies the first
// byte permutation into a register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_frame_build (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [31:0]        device_id,
    input  wire logic signed [15:0] temperature,
    input  wire logic [15:0]        humidity,
    output sfc_pkg::sfc_block_t     block
);
    import sfc_pkg::*;

    logic [63:0] plain;
    logic [15:0] crc;
    sfc_block_t  block_next;
    sfc_block_t  block_reg;

    always_comb
    begin
        plain = {humidity, 16'(unsigned'(temperature)), device_id};
        crc   = sfc_crc_base();
        // XOR of the column masks of every set data bit
        for (int j = 0; j < 64; j++)
        begin
            if (plain[j])
            begin
                crc = crc ^ sfc_crc_column(j);
            end
        end
        block_next = sfc_permute({crc, plain});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            block_reg <= block_next;
        end
    end

    assign block = block_reg;

endmodule

`default_nettype wire

[hdl/sfc_round.sv]
// ----------------------------------------------------------------------------
// sfc_round
// One registered Feistel round: S-box, rotate, byte mixes, swap of halves.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_round #(
    parameter int RND = 0
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire sfc_pkg::sfc_block_t blk_in,
    output sfc_pkg::sfc_block_t      blk_out
);
    import sfc_pkg::*;

    localparam sfc_half_t SUBKEY = sfc_subkey(RND);
    localparam int        ROT    = (RND + 1) % 40;

    sfc_half_t   left_half;
    sfc_half_t   right_half;
    sfc_half_t   x;
    sfc_half_t   sub;
    logic [79:0] dbl;
    sfc_half_t   y;
    sfc_byte_t   b0;
    sfc_byte_t   b2;
    sfc_half_t   f;
    sfc_block_t  blk_next;
    sfc_block_t  blk_reg;

    always_comb
    begin
        left_half  = blk_in[39:0];
        right_half = blk_in[79:40];
        x = right_half ^ SUBKEY;
        for (int i = 0; i < 5; i++)
        begin
            sub[8*i +: 8] = sfc_sbox_byte(x[8*i +: 8]);
        end
        // rotate left within 40 bits
        dbl = {sub, sub};
        y   = dbl[40 - ROT +: 40];
        b0  = y[7:0] ^ (y[39:32] + SFC_MIX_ADD);
        b2  = y[23:16] ^ (b0 + y[15:8]);
        f   = {y[39:24], b2, y[15:8], b0};
        blk_next = {left_half ^ f, right_half};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            blk_reg <= blk_next;
        end
    end

    assign blk_out = blk_reg;

endmodule

`default_nettype wire

[hdl/sensor_frame_crc_feistel_encrypt.sv]
// Pipeline: one CRC/permute stage, one stage per Feistel round and one output
// stage lie between an accepted reading and a valid cipher word.
// Throughput: one word per cycle; the whole pipe advances together and holds
// while the output word waits.
// Reset: rst_n clears all valid flags and device_id to zero asynchronously.
// ----------------------------------------------------------------------------
// sensor_frame_crc_feistel_encrypt
// Seals a sensor reading: device id + reading + CRC16, encrypted by a
// 10-byte Feistel cipher with fixed subkeys.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_crc_feistel_encrypt #(
    parameter int ROUND_COUNT = sfc_pkg::SFC_ROUND_COUNT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    sfc_in_if.sink           sensor,
    sfc_out_if.source        cipher
);
    import sfc_pkg::*;

    localparam int STAGES = ROUND_COUNT + 2;

    logic [31:0]       device_id_reg;
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic              advance;
    sfc_block_t        stage_data [ROUND_COUNT+1];
    sfc_block_t        final_blk;
    sfc_block_t        cipher_next;
    sfc_block_t        cipher_reg;

    // advance everything unless the output word is stalled
    assign advance      = !valid_reg[STAGES-1] || cipher.ready;
    assign sensor.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= SFC_DEVICE_ID_RST;
        end
        else if (cfg_we)
        begin
            device_id_reg <= cfg_wdata;
        end
    end

    assign valid_next = {valid_reg[STAGES-2:0], sensor.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    sfc_frame_build u_frame (
        .clk         (clk),
        .en          (advance),
        .device_id   (device_id_reg),
        .temperature (sensor.temperature),
        .humidity    (sensor.humidity),
        .block       (stage_data[0])
    );

    for (genvar r = 0; r < ROUND_COUNT; r++)
    begin : g_round
        sfc_round #(
            .RND (r)
        ) u_round (
            .clk     (clk),
            .en      (advance),
            .blk_in  (stage_data[r]),
            .blk_out (stage_data[r+1])
        );
    end

    // join as R || L, then the same byte permutation again
    assign final_blk   = stage_data[ROUND_COUNT];
    assign cipher_next = sfc_permute({final_blk[39:0], final_blk[79:40]});

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cipher_reg <= cipher_next;
        end
    end

    assign cipher.valid       = valid_reg[STAGES-1];
    assign cipher.cipher_low  = cipher_reg[63:0];
    assign cipher.cipher_high = cipher_reg[79:64];

endmodule

`default_nettype wire
